/* hw/rtl/rpb_pkg.sv */
// rpb_pkg: shared types and constants for the rssi proximity beeper
// used by rpb_beep_calc and rssi_proximity_beeper_top, depends on nothing else
`default_nettype none

package rpb_pkg;

    // register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_STALE_TIMEOUT = 2'd0,
        REG_IDLE_PERIOD   = 2'd1,
        REG_BEEP_DURATION = 2'd2
    } rpb_reg_idx_t;

    // request kinds carried in tuser
    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_SIGHTING = 1'b1;

    // configuration reset values
    localparam logic [12:0] STALE_TIMEOUT_RESET = 13'd4000;
    localparam logic [11:0] IDLE_PERIOD_RESET   = 12'd1200;
    localparam logic [7:0]  BEEP_DURATION_RESET = 8'd50;

    // state reset values and limits
    localparam logic signed [7:0] RSSI_RESET   = -8'sd128;
    localparam logic [11:0]       PERIOD_RESET = 12'd1200;
    localparam logic [12:0]       AGE_MAX      = 13'h1FFF;
    localparam logic [11:0]       COUNT_MAX    = 12'hFFF;

    // rssi thresholds in dBm
    localparam logic signed [7:0] NEAR_RSSI  = -8'sd84;
    localparam logic signed [7:0] CLOSE_RSSI = -8'sd45;
    localparam logic signed [7:0] MID_RSSI   = -8'sd60;
    localparam logic signed [7:0] FAR_RSSI   = -8'sd72;

    // period ladder in ms
    localparam logic [11:0] PERIOD_CLOSE = 12'd80;
    localparam logic [11:0] PERIOD_MID   = 12'd160;
    localparam logic [11:0] PERIOD_FAR   = 12'd300;
    localparam logic [11:0] PERIOD_NEAR  = 12'd600;

    // pitch line 600 + (rssi + 100) * 30, clamped
    localparam logic signed [15:0] PITCH_BASE   = 16'sd600;
    localparam logic signed [15:0] PITCH_SLOPE  = 16'sd30;
    localparam logic signed [9:0]  PITCH_OFFSET = 10'sd100;
    localparam logic signed [15:0] PITCH_MIN    = 16'sd600;
    localparam logic signed [15:0] PITCH_MAX    = 16'sd3500;

    // volume about 89 + d * 166 / 39 with d = rssi + 84, done as d * 1115852 >> 18
    localparam logic [7:0]  VOL_BASE   = 8'd89;
    localparam logic [7:0]  VOL_FULL   = 8'd255;
    localparam logic [7:0]  VOL_OFFSET = 8'd84;
    localparam logic [20:0] VOL_RECIP  = 21'd1115852;
    localparam int          VOL_SHIFT  = 18;

    typedef struct packed {
        logic [11:0] pitch_hz;
        logic [7:0]  volume;
        logic        audible;
        logic [11:0] ladder_period;
    } rpb_beep_t;

endpackage

`default_nettype wire

/* hw/rtl/rpb_beep_calc.sv */
// rpb_beep_calc: pitch, volume and next period derived from the stored rssi
// depends on rpb_pkg
`default_nettype none

module rpb_beep_calc
    import rpb_pkg::*;
(
    input  wire logic signed [7:0] rssi,
    input  wire logic [11:0]       idle_period,
    output rpb_beep_t              beep
);

    logic signed [9:0]  rssi_ofs;
    logic signed [15:0] hz_full;
    logic [7:0]         vol_sum;
    logic [5:0]         vol_d;
    logic [26:0]        vol_prod;

    // pitch
    always_comb
    begin
        rssi_ofs = $signed({{2{rssi[7]}}, rssi}) + PITCH_OFFSET;
        hz_full  = PITCH_BASE + $signed({{6{rssi_ofs[9]}}, rssi_ofs}) * PITCH_SLOPE;
        if (hz_full < PITCH_MIN)
        begin
            beep.pitch_hz = PITCH_MIN[11:0];
        end
        else if (hz_full > PITCH_MAX)
        begin
            beep.pitch_hz = PITCH_MAX[11:0];
        end
        else
        begin
            beep.pitch_hz = hz_full[11:0];
        end
    end

    // volume, d only matters between the two thresholds where it is 1..38
    always_comb
    begin
        vol_sum  = rssi + VOL_OFFSET;
        vol_d    = vol_sum[5:0];
        vol_prod = 27'(vol_d) * 27'(VOL_RECIP);
        if (rssi <= NEAR_RSSI)
        begin
            beep.volume = 8'd0;
        end
        else if (rssi >= CLOSE_RSSI)
        begin
            beep.volume = VOL_FULL;
        end
        else
        begin
            beep.volume = VOL_BASE + vol_prod[VOL_SHIFT +: 8];
        end
    end

    // period ladder
    always_comb
    begin
        beep.audible = (rssi > NEAR_RSSI);
        if (rssi > CLOSE_RSSI)
        begin
            beep.ladder_period = PERIOD_CLOSE;
        end
        else if (rssi > MID_RSSI)
        begin
            beep.ladder_period = PERIOD_MID;
        end
        else if (rssi > FAR_RSSI)
        begin
            beep.ladder_period = PERIOD_FAR;
        end
        else if (rssi > NEAR_RSSI)
        begin
            beep.ladder_period = PERIOD_NEAR;
        end
        else
        begin
            beep.ladder_period = idle_period;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rssi_proximity_beeper_top.sv */
// rssi_proximity_beeper_top: geiger-style proximity beeper with apb configuration
// depends on rpb_pkg and rpb_beep_calc
//
// channel   direction  handshake                        payload
// s_axis    in         s_axis_tvalid / s_axis_tready    tdata = rssi, tuser = kind
// m_axis    out        m_axis_tvalid / m_axis_tready    tdata = pitch, volume, duration, period
// apb       in         psel / penable / pready          stale timeout, idle period, duration
//
// one request per clock while no beep waits or m_axis_tready is high; once its tick is taken a beep
// passes the input register, then the result register, a tick or sighting with no beep shows nothing
// rst_n clears all control state and loads the configuration defaults
// while m_axis_tready is low a waiting beep holds, the input register still fills,
// and s_axis_tready falls only when both registers are occupied
`default_nettype none

module rssi_proximity_beeper_top
    import rpb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rssi (signed dBm)
    input  wire logic        s_axis_tuser,   // [0] kind: 0 tick, 1 sighting

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [11:0] pitch_hz, [19:12] volume,
                                             // [27:20] duration_ms, [39:28] period_ms

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration
    logic [12:0] stale_timeout_reg;
    logic [11:0] idle_period_reg;
    logic [7:0]  beep_duration_reg;
    logic        cfg_write;
    rpb_reg_idx_t cfg_idx;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic              in_kind_reg;
    logic signed [7:0] in_rssi_reg;
    logic              in_load;

    // beeper state
    logic signed [7:0] last_rssi_reg, last_rssi_next;
    logic [12:0]       age_reg, age_next;
    logic [11:0]       count_reg, count_next;
    logic [11:0]       period_reg, period_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg;

    // per-request work
    logic        advance;
    logic        is_tick;
    logic [12:0] age_inc;
    logic [11:0] count_inc;
    logic        stale;
    logic        period_hit;
    logic        emit;
    rpb_beep_t   beep;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = rpb_reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_timeout_reg <= STALE_TIMEOUT_RESET;
            idle_period_reg   <= IDLE_PERIOD_RESET;
            beep_duration_reg <= BEEP_DURATION_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_STALE_TIMEOUT: stale_timeout_reg <= pwdata[12:0];
                REG_IDLE_PERIOD:   idle_period_reg   <= pwdata[11:0];
                REG_BEEP_DURATION: beep_duration_reg <= pwdata[7:0];
                default:           ;  // unmapped slot, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_STALE_TIMEOUT: prdata = {19'd0, stale_timeout_reg};
            REG_IDLE_PERIOD:   prdata = {20'd0, idle_period_reg};
            REG_BEEP_DURATION: prdata = {24'd0, beep_duration_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- handshakes ----------------
    // the request in the input register retires when the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_load       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_kind_reg <= s_axis_tuser;
            in_rssi_reg <= s_axis_tdata;
        end
    end

    // ---------------- beep computation ----------------
    rpb_beep_calc u_beep_calc (
        .rssi        (last_rssi_reg),
        .idle_period (idle_period_reg),
        .beep        (beep)
    );

    always_comb
    begin
        is_tick    = (in_kind_reg == KIND_TICK);
        // age saturates so a full-scale timeout never goes stale
        age_inc    = (age_reg < AGE_MAX) ? age_reg + 13'd1 : age_reg;
        count_inc  = (count_reg < COUNT_MAX) ? count_reg + 12'd1 : count_reg;
        stale      = (age_inc > stale_timeout_reg);
        period_hit = (count_inc >= period_reg);
        emit       = advance && is_tick && period_hit && !stale && beep.audible;
    end

    always_comb
    begin
        last_rssi_next = last_rssi_reg;
        age_next       = age_reg;
        count_next     = count_reg;
        period_next    = period_reg;
        if (advance)
        begin
            if (in_kind_reg == KIND_SIGHTING)
            begin
                // sighting refreshes the signal, counter untouched
                last_rssi_next = in_rssi_reg;
                age_next       = 13'd0;
            end
            else
            begin
                age_next = age_inc;
                if (period_hit)
                begin
                    // period elapsed: restart and reload, beep or not
                    count_next  = 12'd0;
                    period_next = stale ? idle_period_reg : beep.ladder_period;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_rssi_reg <= RSSI_RESET;
            age_reg       <= 13'd0;
            count_reg     <= 12'd0;
            period_reg    <= PERIOD_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            last_rssi_reg <= last_rssi_next;
            age_reg       <= age_next;
            count_reg     <= count_next;
            period_reg    <= period_next;
        end
    end

    // result payload, period reported is the one in force before the reload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {period_reg, beep_duration_reg, beep.volume, beep.pitch_hz};
        end
    end

    // ---------------- assertions ----------------
    a_beep_restarts_counter: assert property (
        @(posedge clk) disable iff (!rst_n)
        emit |=> (count_reg == 12'd0))
        else $error("counter not restarted after a beep");

    a_sighting_clears_age: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && in_kind_reg == KIND_SIGHTING) |=> (age_reg == 13'd0))
        else $error("signal age not cleared by a sighting");

    a_beep_is_audible: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[11:0] >= 12'd1110 && out_data_reg[19:12] >= VOL_BASE))
        else $error("beep emitted for a signal at or below the near threshold");

    a_stall_needs_full_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room to take a request");

endmodule

`default_nettype wire
